/* rtl/seag_pkg.sv */
// Shared constants and types for the scatter address generator.
`timescale 1ns / 1ps
package seag_pkg;

  localparam int ADDR_WIDTH      = 32;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int AXIS_WIDTH      = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_SCATTER_AXIS = 2'd0,
    CFG_DATA_SHAPE   = 2'd1,
    CFG_INDEX_SHAPE  = 2'd2
  } cfg_reg_t;

endpackage

/* rtl/scatter_elements_address_gen.sv */
// Scatter-along-axis write-address generator: index check, odometer, address sum.
`timescale 1ns / 1ps
// Usage:
//   s_* channel: one beat per element of the indices tensor, row-major order,
//     carrying the signed index and the update word.
//   m_* channel: one beat per input beat, same order: flat write address
//     (zero on error), update word, index error in tuser, tlast on the final
//     element of the indices tensor.
//   cfg_*: write enable, register index, data; axis, data shape, index shape.
// Throughput: one beat per cycle while m_tready and s_tready are high, through the
//   three-stage pipe (captured beat; index check and stride multiply into the products;
//   address sum into the output register).
// After reset and after each configuration write, s_tready stays low while the stride
//   chain (one registered multiply per dimension but the last) recomputes.
// Reset clears the odometer, sets axis 0 and all sizes to 1.
// A stall on m_tready fills the pipe; s_tready drops once all stages are full.
module scatter_elements_address_gen
  import seag_pkg::*;
#(
  parameter int MAX_RANK    = 4,
  parameter int DIM_WIDTH   = 16,
  parameter int DATA_WIDTH  = 64,
  parameter int INDEX_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]                    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]                     cfg_data,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // index_value, update_value
  input  logic [((INDEX_WIDTH+DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // write_address, write_value
  output logic [((ADDR_WIDTH+DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
  // index_error
  output logic                                          m_tuser,
  output logic                                          m_tlast
);

  localparam int OUT_TDATA_W = ((ADDR_WIDTH + DATA_WIDTH + 7) / 8) * 8;
  localparam int PAD_W       = MAX_RANK * DIM_WIDTH + CFG_DATA_WIDTH;
  localparam int AXW         = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CW          = ((INDEX_WIDTH > DIM_WIDTH) ? INDEX_WIDTH : DIM_WIDTH) + 1;
  localparam int SW          = $clog2(MAX_RANK + 1);

  function automatic logic [CFG_DATA_WIDTH-1:0] shape_ones();
    logic [CFG_DATA_WIDTH-1:0] v;
    v = '0;
    for (int d = 0; d < MAX_RANK; d++) begin
      if (d * DIM_WIDTH < CFG_DATA_WIDTH) begin
        v[d*DIM_WIDTH] = 1'b1;
      end
    end
    return v;
  endfunction

  // configuration
  logic [AXIS_WIDTH-1:0]     axis_reg;
  logic [CFG_DATA_WIDTH-1:0] data_shape;
  logic [CFG_DATA_WIDTH-1:0] index_shape;
  logic [SW-1:0]             settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_reg    <= '0;
      data_shape  <= shape_ones();
      index_shape <= shape_ones();
      settle      <= SW'(MAX_RANK);
    end else if (cfg_we) begin
      settle <= SW'(MAX_RANK);
      case (cfg_index)
        CFG_SCATTER_AXIS: axis_reg    <= cfg_data[AXIS_WIDTH-1:0];
        CFG_DATA_SHAPE:   data_shape  <= cfg_data;
        CFG_INDEX_SHAPE:  index_shape <= cfg_data;
        default: ;
      endcase
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // dimension sizes, zero read as one
  logic [DIM_WIDTH-1:0] data_dim  [MAX_RANK];
  logic [DIM_WIDTH-1:0] index_dim [MAX_RANK];
  logic [PAD_W-1:0]     data_pad;
  logic [PAD_W-1:0]     index_pad;

  always_comb begin
    data_pad  = PAD_W'(data_shape);
    index_pad = PAD_W'(index_shape);
    for (int d = 0; d < MAX_RANK; d++) begin
      data_dim[d]  = data_pad[(MAX_RANK-1-d)*DIM_WIDTH +: DIM_WIDTH];
      index_dim[d] = index_pad[(MAX_RANK-1-d)*DIM_WIDTH +: DIM_WIDTH];
      if (data_dim[d] == '0) data_dim[d] = DIM_WIDTH'(1);
      if (index_dim[d] == '0) index_dim[d] = DIM_WIDTH'(1);
    end
  end

  logic [AXW-1:0] axis_sel;
  always_comb begin
    if (32'(axis_reg) >= 32'(MAX_RANK)) axis_sel = AXW'(MAX_RANK - 1);
    else axis_sel = AXW'(axis_reg);
  end

  // strides, one registered multiply per dimension but the last
  logic [ADDR_WIDTH-1:0] stride [MAX_RANK];
  logic [ADDR_WIDTH-1:0] stride_full [MAX_RANK];

  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      if (d == MAX_RANK - 1) stride_full[d] = ADDR_WIDTH'(1);
      else stride_full[d] = stride[d+1] * ADDR_WIDTH'(data_dim[d+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_RANK; d++) begin
      stride[d] <= stride_full[d];
    end
  end

  // handshake chain
  logic v1, v2, ov;
  logic rdy1, rdy2, rdy_out, accept;

  assign rdy_out  = !ov || m_tready;
  assign rdy2     = !v2 || rdy_out;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1 && (settle == '0);
  assign accept   = s_tvalid && s_tready;

  // odometer
  logic [DIM_WIDTH-1:0] coord      [MAX_RANK];
  logic [DIM_WIDTH-1:0] coord_next [MAX_RANK];
  logic                 wrap       [MAX_RANK];
  logic                 carry;
  logic                 last_next;

  always_comb begin
    carry = 1'b1;
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      wrap[d] = ({1'b0, coord[d]} + 1'b1) >= {1'b0, index_dim[d]};
      coord_next[d] = coord[d];
      if (carry) begin
        coord_next[d] = wrap[d] ? '0 : coord[d] + 1'b1;
      end
      carry = carry && wrap[d];
    end
    last_next = carry;
  end

  // stage 1: captured beat
  logic [INDEX_WIDTH-1:0] idx1;
  logic [DATA_WIDTH-1:0]  val1;
  logic [DIM_WIDTH-1:0]   coord1 [MAX_RANK];
  logic                   last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      for (int d = 0; d < MAX_RANK; d++) coord[d] <= '0;
    end else begin
      if (rdy1) v1 <= accept;
      if (accept) begin
        for (int d = 0; d < MAX_RANK; d++) coord[d] <= coord_next[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx1  <= s_tdata[INDEX_WIDTH-1:0];
      val1  <= s_tdata[INDEX_WIDTH +: DATA_WIDTH];
      last1 <= last_next;
      for (int d = 0; d < MAX_RANK; d++) coord1[d] <= coord[d];
    end
  end

  // index check and per-dimension products
  logic [DIM_WIDTH-1:0]   axis_len;
  logic [INDEX_WIDTH-1:0] mag;
  logic                   err1;
  logic [DIM_WIDTH-1:0]   pos1;
  logic [ADDR_WIDTH-1:0]  prod_full [MAX_RANK];

  always_comb begin
    axis_len = data_dim[axis_sel];
    mag      = ~idx1 + 1'b1;
    if (idx1[INDEX_WIDTH-1]) begin
      err1 = CW'(mag) > CW'(axis_len);
      pos1 = axis_len - DIM_WIDTH'(mag);
    end else begin
      err1 = CW'(idx1) >= CW'(axis_len);
      pos1 = DIM_WIDTH'(idx1);
    end
    for (int d = 0; d < MAX_RANK; d++) begin
      if (AXW'(d) == axis_sel) prod_full[d] = ADDR_WIDTH'(pos1) * stride[d];
      else prod_full[d] = ADDR_WIDTH'(coord1[d]) * stride[d];
    end
  end

  // stage 2: products
  logic [ADDR_WIDTH-1:0] prod2 [MAX_RANK];
  logic [DATA_WIDTH-1:0] val2;
  logic                  err2, last2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (rdy2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int d = 0; d < MAX_RANK; d++) prod2[d] <= prod_full[d];
      val2  <= val1;
      err2  <= err1;
      last2 <= last1;
    end
  end

  logic [ADDR_WIDTH-1:0] addr_sum;
  always_comb begin
    addr_sum = '0;
    for (int d = 0; d < MAX_RANK; d++) addr_sum = addr_sum + prod2[d];
  end

  // output register
  logic [ADDR_WIDTH-1:0] out_addr;
  logic [DATA_WIDTH-1:0] out_val;
  logic                  out_err, out_last;

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (rdy_out) ov <= v2;
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v2) begin
      out_addr <= err2 ? '0 : addr_sum;
      out_val  <= val2;
      out_err  <= err2;
      out_last <= last2;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = OUT_TDATA_W'({out_val, out_addr});
  assign m_tuser  = out_err;
  assign m_tlast  = out_last;

endmodule
